// ===== hw/rtl/tcp_option_rewriter_macros.svh =====
// Assertion macros shared by the TCP option rewriter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TCP_OPTION_REWRITER_MACROS_SVH
`define TCP_OPTION_REWRITER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TOR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TOR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TOR_ASSERT(lbl, clk, rst, prop, msg)
`define TOR_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/tcpor_pkg.sv =====
// Types and constants for the TCP option rewriter.
// No dependencies; imported by tcpor_parser, tcp_option_rewriter and the bench.
package tcpor_pkg;

   localparam logic [7:0] KIND_EOL       = 8'd0;
   localparam logic [7:0] KIND_NOP       = 8'd1;
   localparam logic [7:0] KIND_MSS       = 8'd2;
   localparam logic [7:0] KIND_WSCALE    = 8'd3;
   localparam logic [7:0] KIND_SACK_PERM = 8'd4;

   localparam logic [7:0] LEN_MIN       = 8'd2;
   localparam logic [7:0] LEN_MSS       = 8'd4;
   localparam logic [7:0] LEN_WSCALE    = 8'd3;
   localparam logic [7:0] LEN_SACK_PERM = 8'd2;

   localparam logic [15:0] SACK_OLD_EVEN = 16'h0402;
   localparam logic [15:0] SACK_OLD_ODD  = 16'h0204;
   localparam logic [15:0] SACK_NEW      = 16'h0101;

   typedef struct packed {
      logic [7:0]  opt_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] checksum_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic        mss_seen;
      logic [15:0] mss_value;
      logic        wscale_seen;
      logic [7:0]  wscale_shift;
      logic        sack_removed;
      logic [15:0] checksum_out;
   } rsp_type;

   // Beats produced by one accepted input beat, packed from slot 0.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

endpackage

// ===== hw/rtl/tcpor_parser.sv =====
// Option parser: parse state, one-byte hold, SACK-permitted rewrite, MSS and window-scale capture, checksum update.
// Depends on tcpor_pkg and tcp_option_rewriter_macros.svh.
`include "tcp_option_rewriter_macros.svh"
module tcpor_parser
   import tcpor_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  req,
   input  logic     extract_enable,
   output push_type push
);

   typedef enum logic [1:0] {PH_KIND, PH_LEN, PH_BODY, PH_STOP} phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic        odd_ff, odd_in;
   logic        kodd_ff, kodd_in;
   logic [7:0]  accum_ff, accum_in;
   logic        mss_found_ff, mss_found_in;
   logic [15:0] mss_keep_ff, mss_keep_in;
   logic        ws_found_ff, ws_found_in;
   logic [7:0]  ws_keep_ff, ws_keep_in;
   logic        sack_ff, sack_in;
   logic [15:0] csum_ff, csum_in;

   logic [7:0]  cur;
   logic [7:0]  held_out;
   logic [7:0]  b;
   rsp_type     held_item;
   rsp_type     last_item;

   function automatic logic [15:0] csum_adjust(input logic [15:0] sum, input logic odd);
      logic [17:0] s;
      logic [16:0] f;
      logic [15:0] oldv;
      oldv = odd ? SACK_OLD_ODD : SACK_OLD_EVEN;
      s = {2'b00, ~sum} + {2'b00, ~oldv} + {2'b00, SACK_NEW};
      f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      return ~(f[15:0] + {15'd0, f[16]});
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      left_in       = left_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      odd_in        = odd_ff;
      kodd_in       = kodd_ff;
      accum_in      = accum_ff;
      mss_found_in  = mss_found_ff;
      mss_keep_in   = mss_keep_ff;
      ws_found_in   = ws_found_ff;
      ws_keep_in    = ws_keep_ff;
      sack_in       = sack_ff;
      csum_in       = csum_ff;
      b             = req.opt_byte;
      cur           = b;
      held_out      = held_ff;

      if (req.first_byte) begin
         phase_in     = PH_KIND;
         odd_in       = 1'b0;
         mss_found_in = 1'b0;
         mss_keep_in  = '0;
         ws_found_in  = 1'b0;
         ws_keep_in   = '0;
         sack_in      = 1'b0;
         csum_in      = req.checksum_in;
      end

      case (phase_in)
         PH_KIND: begin
            if (b == KIND_EOL) begin
               phase_in = PH_STOP;
            end else if (b != KIND_NOP) begin
               kind_in  = b;
               kodd_in  = odd_in;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (b < LEN_MIN) begin
               phase_in = PH_STOP;
            end else if (kind_in == KIND_SACK_PERM && b == LEN_SACK_PERM) begin
               held_out = KIND_NOP;
               cur      = KIND_NOP;
               csum_in  = csum_adjust(csum_in, kodd_in);
               sack_in  = 1'b1;
               phase_in = PH_KIND;
            end else if (b == LEN_MIN) begin
               phase_in = PH_KIND;
            end else begin
               if ((kind_in == KIND_MSS && b != LEN_MSS) ||
                   (kind_in == KIND_WSCALE && b != LEN_WSCALE)) begin
                  kind_in = KIND_EOL;
               end
               left_in  = b - LEN_MIN;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (kind_in == KIND_MSS) begin
               if (left_in == 8'd2) begin
                  accum_in = b;
               end else if (left_in == 8'd1 && extract_enable) begin
                  mss_keep_in  = {accum_in, b};
                  mss_found_in = 1'b1;
               end
            end else if (kind_in == KIND_WSCALE && left_in == 8'd1 && extract_enable) begin
               ws_keep_in  = b;
               ws_found_in = 1'b1;
            end
            left_in = left_in - 8'd1;
            if (left_in == 8'd0) begin
               phase_in = PH_KIND;
            end
         end
         default: begin
         end
      endcase
      odd_in = ~odd_in;

      held_item          = '0;
      held_item.out_byte = held_out;

      last_item              = '0;
      last_item.out_byte     = cur;
      last_item.out_last     = 1'b1;
      last_item.mss_seen     = mss_found_in;
      last_item.mss_value    = mss_keep_in;
      last_item.wscale_seen  = ws_found_in;
      last_item.wscale_shift = ws_keep_in;
      last_item.sack_removed = sack_in;
      last_item.checksum_out = csum_in;

      push.count = {1'b0, held_valid_ff} + {1'b0, req.last_byte};
      push.slot0 = held_valid_ff ? held_item : last_item;
      push.slot1 = last_item;

      if (req.last_byte) begin
         phase_in      = PH_STOP;
         held_valid_in = 1'b0;
      end else begin
         held_in       = cur;
         held_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_KIND;
         kind_ff       <= '0;
         left_ff       <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         odd_ff        <= 1'b0;
         kodd_ff       <= 1'b0;
         accum_ff      <= '0;
         mss_found_ff  <= 1'b0;
         mss_keep_ff   <= '0;
         ws_found_ff   <= 1'b0;
         ws_keep_ff    <= '0;
         sack_ff       <= 1'b0;
         csum_ff       <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         left_ff       <= left_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         odd_ff        <= odd_in;
         kodd_ff       <= kodd_in;
         accum_ff      <= accum_in;
         mss_found_ff  <= mss_found_in;
         mss_keep_ff   <= mss_keep_in;
         ws_found_ff   <= ws_found_in;
         ws_keep_ff    <= ws_keep_in;
         sack_ff       <= sack_in;
         csum_ff       <= csum_in;
      end
   end

   `TOR_ASSERT(a_last_drops_hold, clock, reset, fire && req.last_byte |=> !held_valid_ff, "hold left after last byte")
   `TOR_ASSERT(a_byte_held, clock, reset, fire && !req.last_byte |=> held_valid_ff, "byte not held")
   `TOR_ASSERT(a_stop_after_last, clock, reset, fire && req.last_byte |=> phase_ff == PH_STOP, "parse not stopped after last byte")

endmodule

// ===== hw/rtl/tcp_option_rewriter.sv =====
// TCP option rewriter top level: one option byte per cycle while req_ready is high, results after one byte of lag.
// A held beat enters the result queue when the byte that follows it is accepted; the final
// byte of an area enters it, behind any held beat, when it is itself accepted.
// Throughput: one input beat per cycle while the four-entry result queue holds at most two beats.
// Reset: synchronous active high; clears parse state and queue, extract_enable returns to 1.
// Depends on tcpor_pkg, tcpor_parser and tcp_option_rewriter_macros.svh.
`include "tcp_option_rewriter_macros.svh"
module tcp_option_rewriter
   import tcpor_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rsp_type        queue_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           extract_ff;
   logic           fire;
   logic           pop;
   logic [PW-1:0]  wr_ptr_next;
   push_type       push;

   assign req_ready   = count_ff <= CW'(DEPTH - 2);
   assign fire        = req_valid && req_ready;
   assign rsp_valid   = count_ff != '0;
   assign pop         = rsp_valid && rsp_ready;
   assign rsp_data    = queue_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + PW'(1);

   tcpor_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .req            (req_data),
      .extract_enable (extract_ff),
      .push           (push)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      if (fire) begin
         wr_ptr_in = wr_ptr_ff + PW'(push.count);
         count_in  = count_ff + CW'(push.count);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PW'(1);
         count_in  = count_in - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         extract_ff <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (csr_wr_en) begin
            extract_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && push.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push.slot0;
      end
      if (fire && push.count == 2'd2) begin
         queue_ff[wr_ptr_next] <= push.slot1;
      end
   end

   `TOR_ASSERT_NEVER(a_queue_overflow, clock, reset, count_ff > CW'(DEPTH), "result queue overflow")
   `TOR_ASSERT(a_count_push, clock, reset, fire && !pop |=> count_ff == $past(count_ff) + CW'($past(push.count)), "queue count lost a push")
   `TOR_ASSERT(a_count_pop, clock, reset, !fire && pop |=> count_ff == $past(count_ff) - CW'(1), "queue count lost a pop")

endmodule

// ===== bench/tcp_option_rewriter_test.sv =====
// Self-checking bench for tcp_option_rewriter: option bytes in, rewritten beats out.
// Predicts every beat in place and compares it field by field as it is accepted.
// Depends on tcpor_pkg and the tcp_option_rewriter RTL.
module tcp_option_rewriter_test;
   import tcpor_pkg::*;

   localparam logic [7:0] KIND_TIMESTAMP = 8'd8;
   localparam logic [7:0] LEN_TIMESTAMP  = 8'd10;
   localparam logic [7:0] KIND_UNKNOWN   = 8'd9;

   typedef enum logic [1:0] {AWAIT_KIND, AWAIT_LEN, IN_BODY, STOPPED} parse_step_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;

   tcp_option_rewriter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rsp_type     rewritten_beats[$];
   logic [7:0]  seg_bytes[$];
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned beats_seen = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned ready_hold_cycles = 0;

   bit             extract_on = 1'b1;
   parse_step_type parse_at = AWAIT_KIND;
   logic [7:0]     opt_kind = '0;
   logic [7:0]     body_left = '0;
   logic [7:0]     held_byte = '0;
   bit             held_pending = 1'b0;
   bit             at_odd_offset = 1'b0;
   bit             kind_at_odd = 1'b0;
   logic [7:0]     mss_high = '0;
   bit             mss_found = 1'b0;
   logic [15:0]    mss_kept = '0;
   bit             shift_found = 1'b0;
   logic [7:0]     shift_kept = '0;
   bit             sack_replaced = 1'b0;
   logic [15:0]    running_csum = '0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 400000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [15:0] adjust_checksum(logic [15:0] sum, logic [15:0] old_word,
                                                   logic [15:0] new_word);
      logic [17:0] acc;
      acc = {2'b0, ~sum} + {2'b0, ~old_word} + {2'b0, new_word};
      acc = {2'b0, acc[15:0]} + {16'b0, acc[17:16]};
      acc = {2'b0, acc[15:0]} + {16'b0, acc[17:16]};
      return ~acc[15:0];
   endfunction

   function automatic rsp_type summary_beat(logic [7:0] b, bit last);
      rsp_type beat;
      beat.out_byte     = b;
      beat.out_last     = last;
      beat.mss_seen     = last & mss_found;
      beat.mss_value    = (last && mss_found) ? mss_kept : 16'h0;
      beat.wscale_seen  = last & shift_found;
      beat.wscale_shift = (last && shift_found) ? shift_kept : 8'h0;
      beat.sack_removed = last & sack_replaced;
      beat.checksum_out = last ? running_csum : 16'h0;
      return beat;
   endfunction

   task automatic rewrite_option_byte(req_type item);
      logic [7:0] b;
      logic [7:0] passed;
      b = item.opt_byte;
      passed = b;
      if (item.first_byte) begin
         if (held_pending) begin
            rewritten_beats.push_back(summary_beat(held_byte, 1'b0));
            held_pending = 1'b0;
         end
         parse_at = AWAIT_KIND;
         at_odd_offset = 1'b0;
         mss_found = 1'b0;
         mss_kept = '0;
         shift_found = 1'b0;
         shift_kept = '0;
         sack_replaced = 1'b0;
         running_csum = item.checksum_in;
      end
      case (parse_at)
         AWAIT_KIND: begin
            if (b == KIND_EOL) begin
               parse_at = STOPPED;
            end else if (b != KIND_NOP) begin
               opt_kind = b;
               kind_at_odd = at_odd_offset;
               parse_at = AWAIT_LEN;
            end
         end
         AWAIT_LEN: begin
            if (b < LEN_MIN) begin
               parse_at = STOPPED;
            end else if (opt_kind == KIND_SACK_PERM && b == LEN_SACK_PERM) begin
               if (held_pending) held_byte = KIND_NOP;
               passed = KIND_NOP;
               running_csum = adjust_checksum(running_csum,
                                              kind_at_odd ? SACK_OLD_ODD : SACK_OLD_EVEN,
                                              SACK_NEW);
               sack_replaced = 1'b1;
               parse_at = AWAIT_KIND;
            end else if (b == LEN_MIN) begin
               parse_at = AWAIT_KIND;
            end else begin
               // drop capture of a misshapen MSS or window scale option
               if ((opt_kind == KIND_MSS && b != LEN_MSS) ||
                   (opt_kind == KIND_WSCALE && b != LEN_WSCALE))
                  opt_kind = KIND_EOL;
               body_left = b - LEN_MIN;
               parse_at = IN_BODY;
            end
         end
         IN_BODY: begin
            if (opt_kind == KIND_MSS) begin
               if (body_left == 8'd2) begin
                  mss_high = b;
               end else if (body_left == 8'd1 && extract_on) begin
                  mss_kept = {mss_high, b};
                  mss_found = 1'b1;
               end
            end else if (opt_kind == KIND_WSCALE && body_left == 8'd1 && extract_on) begin
               shift_kept = b;
               shift_found = 1'b1;
            end
            body_left = body_left - 8'd1;
            if (body_left == 8'd0) parse_at = AWAIT_KIND;
         end
         default: ;
      endcase
      at_odd_offset = ~at_odd_offset;
      if (held_pending) begin
         rewritten_beats.push_back(summary_beat(held_byte, 1'b0));
         held_pending = 1'b0;
      end
      if (item.last_byte) begin
         rewritten_beats.push_back(summary_beat(passed, 1'b1));
         parse_at = STOPPED;
      end else begin
         held_byte = passed;
         held_pending = 1'b1;
      end
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch at beat %0d: %s", beats_seen, msg);
   endtask

   task automatic compare_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", field, got, want));
   endtask

   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (rewritten_beats.size() == 0) begin
            report_mismatch("unexpected beat");
         end else begin
            want = rewritten_beats.pop_front();
            compare_field("out_byte", rsp_data.out_byte, want.out_byte);
            compare_field("out_last", rsp_data.out_last, want.out_last);
            compare_field("mss_seen", rsp_data.mss_seen, want.mss_seen);
            compare_field("mss_value", rsp_data.mss_value, want.mss_value);
            compare_field("wscale_seen", rsp_data.wscale_seen, want.wscale_seen);
            compare_field("wscale_shift", rsp_data.wscale_shift, want.wscale_shift);
            compare_field("sack_removed", rsp_data.sack_removed, want.sack_removed);
            compare_field("checksum_out", rsp_data.checksum_out, want.checksum_out);
         end
         beats_seen++;
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (ready_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (ready_hold_cycles) @(posedge clock);
            ready_hold_cycles = 0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 11)) @(posedge clock);
      end
   end

   task automatic send_beat(logic [7:0] b, bit first, bit last, logic [15:0] csum);
      req_type item;
      item.opt_byte    = b;
      item.first_byte  = first;
      item.last_byte   = last;
      item.checksum_in = csum;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      rewrite_option_byte(item);
      bytes_sent++;
   endtask

   task automatic send_segment(logic [15:0] csum, bit with_last);
      for (int i = 0; i < seg_bytes.size(); i++)
         send_beat(seg_bytes[i], i == 0, with_last && i == seg_bytes.size() - 1,
                   (i == 0) ? csum : 16'($urandom));
   endtask

   task automatic add_random_option();
      logic [7:0] kind;
      logic [7:0] len;
      case ($urandom_range(0, 11))
         0: seg_bytes.push_back(KIND_NOP);
         1, 2: begin
            seg_bytes.push_back(KIND_MSS);
            seg_bytes.push_back(LEN_MSS);
            seg_bytes.push_back(8'($urandom));
            seg_bytes.push_back(8'($urandom));
         end
         3, 4: begin
            seg_bytes.push_back(KIND_WSCALE);
            seg_bytes.push_back(LEN_WSCALE);
            seg_bytes.push_back(8'($urandom));
         end
         5, 6: begin
            seg_bytes.push_back(KIND_SACK_PERM);
            seg_bytes.push_back(LEN_SACK_PERM);
         end
         7: begin
            seg_bytes.push_back(KIND_TIMESTAMP);
            seg_bytes.push_back(LEN_TIMESTAMP);
            repeat (LEN_TIMESTAMP - LEN_MIN) seg_bytes.push_back(8'($urandom));
         end
         8, 9: begin
            kind = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(5, 255))
                 : (($urandom_range(0, 1) == 0) ? KIND_MSS : KIND_WSCALE);
            len = 8'($urandom_range(2, 8));
            seg_bytes.push_back(kind);
            seg_bytes.push_back(len);
            repeat (len - LEN_MIN) seg_bytes.push_back(8'($urandom));
         end
         10: begin
            seg_bytes.push_back(8'($urandom_range(2, 255)));
            seg_bytes.push_back(8'($urandom_range(0, 1)));
         end
         default: begin
            seg_bytes.push_back(KIND_EOL);
            repeat ($urandom_range(0, 3)) seg_bytes.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic send_random_segment();
      seg_bytes.delete();
      repeat ($urandom_range(1, 5)) add_random_option();
      if (seg_bytes.size() > 1 && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, seg_bytes.size() - 1)) void'(seg_bytes.pop_back());
      send_segment(16'($urandom), $urandom_range(0, 19) != 0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_beat(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                   16'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (rewritten_beats.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_extract_enable(bit on);
      csr_wr_data <= on;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      extract_on = on;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_before_first_segment();
      send_beat(KIND_SACK_PERM, 1'b0, 1'b0, 16'hFFFF);
      send_beat(LEN_SACK_PERM, 1'b0, 1'b1, 16'h0000);
   endtask

   task automatic test_directed_segments();
      seg_bytes = '{KIND_NOP, KIND_SACK_PERM, LEN_SACK_PERM, KIND_MSS, LEN_MSS, 8'hFF, 8'hFF,
                    KIND_WSCALE, LEN_WSCALE, 8'hFF};
      send_segment(16'hFFFF, 1'b1);
      send_beat(KIND_SACK_PERM, 1'b0, 1'b0, 16'hFFFF);
      seg_bytes = '{KIND_SACK_PERM, LEN_SACK_PERM, KIND_WSCALE, LEN_MIN, KIND_MSS, 8'd3, 8'h00,
                    KIND_UNKNOWN, 8'd1};
      send_segment(16'h0000, 1'b1);
      seg_bytes = '{KIND_MSS, LEN_MSS, 8'h12};
      send_segment(16'h8001, 1'b1);
      seg_bytes = '{KIND_EOL};
      send_segment(16'h7FFE, 1'b1);
   endtask

   task automatic test_backpressure();
      int unsigned stop_at;
      stop_at = bytes_sent + 60;
      req_idle_on = 1'b0;
      ready_hold_cycles = 300;
      while (bytes_sent < stop_at) send_random_segment();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_segments();
      bit          setting;
      int unsigned stop_at;
      setting = 1'b0;
      repeat (8) begin
         settle();
         write_extract_enable(setting);
         setting = ~setting;
         stop_at = bytes_sent + 160;
         while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0) send_noise();
            else send_random_segment();
         end
      end
   endtask

   task automatic test_steady_stream();
      int unsigned stop_at;
      settle();
      write_extract_enable(1'b1);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      stop_at = bytes_sent + 220;
      while (bytes_sent < stop_at) send_random_segment();
      seg_bytes = '{KIND_MSS, LEN_MSS, 8'h05, 8'hB4, KIND_SACK_PERM, LEN_SACK_PERM};
      send_segment(16'($urandom), 1'b1);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_before_first_segment();
      test_directed_segments();
      test_backpressure();
      test_random_segments();
      test_steady_stream();

      settle();
      repeat (20) @(posedge clock);
      if (rewritten_beats.size() != 0)
         report_mismatch($sformatf("%0d beats never arrived", rewritten_beats.size()));
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
